>>> src/fpec_pkg.sv
// ---------------------------------------------------------------------------
// Flash program/erase controller package
// Holds the operation codes, register indexes, control bits and status codes.
// ---------------------------------------------------------------------------
package fpec_pkg;

    // Geometry defaults. Both must be powers of two.
    localparam int PAGE_COUNT_DEF     = 16;
    localparam int PAGE_HALFWORDS_DEF = 512;

    // Unlock keys.
    localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
    localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

    // Control register bit positions.
    localparam int CR_PG_BIT   = 0;
    localparam int CR_PER_BIT  = 1;
    localparam int CR_MER_BIT  = 2;
    localparam int CR_STRT_BIT = 6;
    localparam int CR_LOCK_BIT = 7;

    // Reset values of the timing registers.
    localparam logic [15:0] PROGRAM_TICKS_RST = 16'd4;
    localparam logic [15:0] ERASE_TICKS_RST   = 16'd64;

    // Erased cell value.
    localparam logic [15:0] ERASED_HALFWORD = 16'hFFFF;

    // Operation codes.
    localparam logic [2:0] OP_REG_READ   = 3'd0;
    localparam logic [2:0] OP_REG_WRITE  = 3'd1;
    localparam logic [2:0] OP_FLASH_READ = 3'd2;
    localparam logic [2:0] OP_FLASH_PROG = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    // Register indexes.
    localparam logic [3:0] REG_KEY     = 4'd1;
    localparam logic [3:0] REG_STATUS  = 4'd3;
    localparam logic [3:0] REG_CONTROL = 4'd4;
    localparam logic [3:0] REG_ADDRESS = 4'd5;

    // Configuration register indexes.
    localparam logic CFG_PROGRAM_TICKS = 1'b0;
    localparam logic CFG_ERASE_TICKS   = 1'b1;

    // Access status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_LOCKED = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;

endpackage

>>> src/flash_program_erase_controller_unit.sv
// ---------------------------------------------------------------------------
// Flash program/erase controller unit
// Key-unlocked controller with its own half-word flash array in one
// synchronous memory; page and mass erase sweep the memory.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   op, reg_index, flash_index, write_value
//  output    out        o_out_valid / i_out_stall read_value, access_status
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Most items are accepted in S_IDLE and their result is then registered to the output.
// A flash read passes through S_FREAD first, since the memory read data is registered.
// A page erase holds off new items while it sweeps one page and a mass erase
// while it sweeps the whole array, one cell written per cycle.
// After reset a clearing pass fills the array with 0xFFFF; no item is accepted
// during it.
// A new item is taken only once the previous result has left the output.
// ---------------------------------------------------------------------------
module flash_program_erase_controller_unit #(
    parameter int PAGE_COUNT     = fpec_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_HALFWORDS = fpec_pkg::PAGE_HALFWORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_reg_index,
    input  logic [12:0] i_flash_index,
    input  logic [31:0] i_write_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_access_status
);
    import fpec_pkg::*;

    localparam int TOTAL = PAGE_COUNT * PAGE_HALFWORDS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int HW_W  = $clog2(PAGE_HALFWORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
    localparam logic [AW-1:0] PAGE_SPAN = AW'(PAGE_HALFWORDS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FREAD, S_ERASE} t_state;

    t_state         r_state,  n_state;
    logic [15:0]    r_program_ticks, r_erase_ticks;
    logic           r_locked, n_locked;
    logic           r_key_stage, n_key_stage;
    logic [2:0]     r_mode, n_mode;
    logic [31:0]    r_erase_address, n_erase_address;
    logic [15:0]    r_busy, n_busy;
    logic [AW-1:0]  r_sweep, n_sweep;
    logic [AW-1:0]  r_last, n_last;
    logic           r_rd_ok, n_rd_ok;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_read_value, n_read_value;
    logic [1:0]     r_status, n_status;
    logic [15:0]    r_rd_data;

    logic [15:0]    mem [TOTAL];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [15:0]    mem_wdata;
    logic           prog_we;

    logic           acc;
    logic           busy;
    logic           in_range;
    logic [31:0]    page_shift;
    logic [AW-1:0]  page_start;

    assign o_in_stall      = !(r_state == S_IDLE && !r_out_valid);
    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_read_value;
    assign o_access_status = r_status;

    assign acc        = i_in_valid && !o_in_stall;
    assign busy       = (r_busy != 16'd0);
    assign in_range   = (32'(i_flash_index) < 32'(TOTAL));
    assign page_shift = r_erase_address >> (HW_W + 1);
    assign page_start = AW'(page_shift << HW_W);

    // Decode the accepted item, present a flash read result and step the sweep.
    always_comb begin
        n_state         = r_state;
        n_locked        = r_locked;
        n_key_stage     = r_key_stage;
        n_mode          = r_mode;
        n_erase_address = r_erase_address;
        n_busy          = r_busy;
        n_sweep         = r_sweep;
        n_last          = r_last;
        n_rd_ok         = r_rd_ok;
        n_out_valid     = r_out_valid && i_out_stall;
        n_read_value    = r_read_value;
        n_status        = r_status;
        prog_we         = 1'b0;

        unique case (r_state)
            S_CLEAR, S_ERASE: begin
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == r_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FREAD: begin
                n_out_valid  = 1'b1;
                n_read_value = r_rd_ok ? {16'd0, r_rd_data} : 32'd0;
                n_status     = ST_DONE;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    n_out_valid  = 1'b1;
                    n_read_value = 32'd0;
                    n_status     = ST_DONE;
                    unique case (i_op)
                        OP_REG_READ: begin
                            priority if (i_reg_index == REG_STATUS) begin
                                n_read_value = {31'd0, busy};
                            end else if (i_reg_index == REG_CONTROL) begin
                                n_read_value = {24'd0, r_locked, 4'd0, r_mode};
                            end else if (i_reg_index == REG_ADDRESS) begin
                                n_read_value = r_erase_address;
                            end else begin
                                n_read_value = 32'd0;
                            end
                        end
                        OP_REG_WRITE: begin
                            priority if (i_reg_index == REG_KEY) begin
                                if (r_locked) begin
                                    priority if (!r_key_stage && i_write_value == KEY_FIRST) begin
                                        n_key_stage = 1'b1;
                                    end else if (r_key_stage
                                                 && i_write_value == KEY_SECOND) begin
                                        n_locked    = 1'b0;
                                        n_key_stage = 1'b0;
                                    end else begin
                                        n_key_stage = 1'b0;
                                    end
                                end
                            end else if (i_reg_index == REG_CONTROL) begin
                                priority if (busy) begin
                                    n_status = ST_BUSY;
                                end else if (i_write_value[CR_LOCK_BIT]) begin
                                    n_locked    = 1'b1;
                                    n_key_stage = 1'b0;
                                    n_mode      = 3'd0;
                                end else if (r_locked) begin
                                    n_status = ST_LOCKED;
                                end else begin
                                    n_mode = i_write_value[2:0];
                                    if (i_write_value[CR_STRT_BIT]) begin
                                        priority if (i_write_value[CR_MER_BIT]) begin
                                            n_sweep = '0;
                                            n_last  = LAST_ADDR;
                                            n_busy  = r_erase_ticks;
                                            n_state = S_ERASE;
                                        end else if (i_write_value[CR_PER_BIT]) begin
                                            n_sweep = page_start;
                                            n_last  = page_start + PAGE_SPAN;
                                            n_busy  = r_erase_ticks;
                                            n_state = S_ERASE;
                                        end else begin
                                            n_state = S_IDLE;
                                        end
                                    end
                                end
                            end else if (i_reg_index == REG_ADDRESS) begin
                                priority if (busy) begin
                                    n_status = ST_BUSY;
                                end else if (r_locked) begin
                                    n_status = ST_LOCKED;
                                end else begin
                                    n_erase_address = i_write_value;
                                end
                            end else begin
                                n_status = ST_DONE;
                            end
                        end
                        OP_FLASH_READ: begin
                            if (busy) begin
                                n_status = ST_BUSY;
                            end else begin
                                // Result waits in S_FREAD for the registered memory data.
                                n_out_valid = 1'b0;
                                n_rd_ok     = in_range;
                                n_state     = S_FREAD;
                            end
                        end
                        OP_FLASH_PROG: begin
                            priority if (busy) begin
                                n_status = ST_BUSY;
                            end else if (r_locked || !r_mode[CR_PG_BIT]) begin
                                n_status = ST_LOCKED;
                            end else if (in_range) begin
                                prog_we = 1'b1;
                                n_busy  = r_program_ticks;
                            end else begin
                                n_status = ST_DONE;
                            end
                        end
                        OP_TICK: begin
                            if (busy) begin
                                n_busy = r_busy - 16'd1;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory write port: the sweep or a program.
    always_comb begin
        mem_we    = (r_state == S_CLEAR) || (r_state == S_ERASE) || prog_we;
        mem_waddr = prog_we ? AW'(i_flash_index) : r_sweep;
        mem_wdata = prog_we ? i_write_value[15:0] : ERASED_HALFWORD;
    end

    // Flash array with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[AW'(i_flash_index)];
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_program_ticks <= PROGRAM_TICKS_RST;
            r_erase_ticks   <= ERASE_TICKS_RST;
            r_locked        <= 1'b1;
            r_key_stage     <= 1'b0;
            r_mode          <= 3'd0;
            r_erase_address <= 32'd0;
            r_busy          <= 16'd0;
            r_sweep         <= '0;
            r_last          <= LAST_ADDR;
            r_rd_ok         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_locked        <= n_locked;
            r_key_stage     <= n_key_stage;
            r_mode          <= n_mode;
            r_erase_address <= n_erase_address;
            r_busy          <= n_busy;
            r_sweep         <= n_sweep;
            r_last          <= n_last;
            r_rd_ok         <= n_rd_ok;
            r_out_valid     <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PROGRAM_TICKS: r_program_ticks <= i_cfg_data;
                    CFG_ERASE_TICKS:   r_erase_ticks   <= i_cfg_data;
                    default:           r_erase_ticks   <= r_erase_ticks;
                endcase
            end
        end
        r_read_value <= n_read_value;
        r_status     <= n_status;
    end

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// Flash program/erase controller testbench
// Drives bus accesses and ticks through the valid/stall input channel and
// compares each result with a cycle-free predictor of the controller and its
// flash array. Timing registers are changed between phases, with no item in flight.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpec_pkg::*;

    localparam int PAGES    = PAGE_COUNT_DEF;
    localparam int PAGE_HW  = PAGE_HALFWORDS_DEF;
    localparam int CELLS    = PAGES * PAGE_HW;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  access_status;
    } t_access_result;

    // Predictor of the controller state and queue of expected results.
    class flash_scoreboard;
        logic [15:0]    cells [CELLS];
        bit             locked;
        bit             key_stage;
        logic [2:0]     mode;
        logic [31:0]    erase_addr;
        logic [15:0]    busy_left;
        logic [15:0]    program_ticks;
        logic [15:0]    erase_ticks;
        t_access_result pending [$];
        int             errors;

        function new();
            foreach (cells[i]) cells[i] = ERASED_HALFWORD;
            locked        = 1'b1;
            key_stage     = 1'b0;
            mode          = '0;
            erase_addr    = '0;
            busy_left     = '0;
            program_ticks = PROGRAM_TICKS_RST;
            erase_ticks   = ERASE_TICKS_RST;
            errors        = 0;
        endfunction

        function void set_timing(logic idx, logic [15:0] v);
            if (idx == CFG_PROGRAM_TICKS) program_ticks = v;
            else erase_ticks = v;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        // Work out the result of one accepted item and update the state.
        function void note_access(logic [2:0] op, logic [3:0] ridx, logic [12:0] fidx,
                                  logic [31:0] wv);
            t_access_result r;
            int page;
            r = '{read_value: '0, access_status: ST_DONE};
            case (op)
                OP_REG_READ: begin
                    if (ridx == REG_STATUS) r.read_value = {31'd0, busy_left != 0};
                    else if (ridx == REG_CONTROL)
                        r.read_value = {24'd0, locked, 4'd0, mode};
                    else if (ridx == REG_ADDRESS) r.read_value = erase_addr;
                end
                OP_REG_WRITE: begin
                    if (ridx == REG_KEY) begin
                        if (locked) begin
                            if (!key_stage && wv == KEY_FIRST) key_stage = 1'b1;
                            else if (key_stage && wv == KEY_SECOND) begin
                                locked    = 1'b0;
                                key_stage = 1'b0;
                            end else key_stage = 1'b0;
                        end
                    end else if (ridx == REG_CONTROL) begin
                        if (busy_left != 0) r.access_status = ST_BUSY;
                        else if (wv[CR_LOCK_BIT]) begin
                            locked    = 1'b1;
                            key_stage = 1'b0;
                            mode      = '0;
                        end else if (locked) r.access_status = ST_LOCKED;
                        else begin
                            mode = wv[2:0];
                            if (wv[CR_STRT_BIT] && mode[CR_MER_BIT]) begin
                                foreach (cells[i]) cells[i] = ERASED_HALFWORD;
                                busy_left = erase_ticks;
                            end else if (wv[CR_STRT_BIT] && mode[CR_PER_BIT]) begin
                                page = ((erase_addr >> 1) / PAGE_HW) % PAGES;
                                for (int i = 0; i < PAGE_HW; i++)
                                    cells[page * PAGE_HW + i] = ERASED_HALFWORD;
                                busy_left = erase_ticks;
                            end
                        end
                    end else if (ridx == REG_ADDRESS) begin
                        if (busy_left != 0) r.access_status = ST_BUSY;
                        else if (locked) r.access_status = ST_LOCKED;
                        else erase_addr = wv;
                    end
                end
                OP_FLASH_READ: begin
                    if (busy_left != 0) r.access_status = ST_BUSY;
                    else if (fidx < CELLS) r.read_value = {16'd0, cells[fidx]};
                end
                OP_FLASH_PROG: begin
                    if (busy_left != 0) r.access_status = ST_BUSY;
                    else if (locked || !mode[CR_PG_BIT]) r.access_status = ST_LOCKED;
                    else if (fidx < CELLS) begin
                        cells[fidx] = wv[15:0];
                        busy_left   = program_ticks;
                    end
                end
                OP_TICK: if (busy_left != 0) busy_left--;
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // Compare one delivered result with the oldest expectation.
        function void check_result(logic [31:0] rv, logic [1:0] st);
            t_access_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result rv=%h st=%0d", rv, st));
                return;
            end
            e = pending.pop_front();
            if (rv !== e.read_value)
                report($sformatf("read_value %h, expected %h", rv, e.read_value));
            if (st !== e.access_status)
                report($sformatf("access_status %0d, expected %0d", st, e.access_status));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_op = '0;
    logic [3:0]  i_reg_index = '0;
    logic [12:0] i_flash_index = '0;
    logic [31:0] i_write_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_read_value;
    logic [1:0]  o_access_status;

    flash_scoreboard sb = new();
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int wait_left = 0;

    flash_program_erase_controller_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: checks each delivered result and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_read_value, o_access_status);
                wait_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted.
    task automatic send(logic [2:0] op, logic [3:0] ridx, logic [12:0] fidx,
                        logic [31:0] wv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_reg_index   <= ridx;
        i_flash_index <= fidx;
        i_write_value <= wv;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_access(op, ridx, fidx, wv);
    endtask

    task automatic write_reg(logic [3:0] ridx, logic [31:0] wv);
        send(OP_REG_WRITE, ridx, '0, wv);
    endtask

    // Wait until every expected result is back and the block takes items.
    task automatic drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0 || o_in_stall) @(posedge i_clk);
    endtask

    task automatic set_timing(logic idx, logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_timing(idx, v);
    endtask

    task automatic unlock();
        write_reg(REG_KEY, KEY_FIRST);
        write_reg(REG_KEY, KEY_SECOND);
    endtask

    // One random item, mostly well-formed traffic of an unlocked controller.
    task automatic random_item();
        int pick;
        logic [31:0] cr;
        pick = $urandom_range(0, 99);
        if (sb.locked && pick < 60) begin
            write_reg(REG_KEY, sb.key_stage ? KEY_SECOND : KEY_FIRST);
        end else if (pick < 25) begin
            send(OP_TICK, 4'($urandom), 13'($urandom), $urandom);
        end else if (pick < 40) begin
            send(OP_FLASH_READ, 4'($urandom), 13'($urandom), $urandom);
        end else if (pick < 62) begin
            send(OP_FLASH_PROG, 4'($urandom), 13'($urandom), $urandom);
        end else if (pick < 72) begin
            send(OP_REG_READ, 4'($urandom_range(0, 15)), 13'($urandom), $urandom);
        end else if (pick < 88) begin
            cr = '0;
            cr[CR_PG_BIT] = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                cr[CR_STRT_BIT] = 1'b1;
                cr[CR_PER_BIT]  = 1'($urandom);
                cr[CR_MER_BIT]  = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 24) == 0) cr[CR_LOCK_BIT] = 1'b1;
            if ($urandom_range(0, 9) == 0) cr = cr | ($urandom & 32'hFFFF_FF38);
            write_reg(REG_CONTROL, cr);
        end else if (pick < 94) begin
            write_reg(REG_ADDRESS, $urandom);
        end else if (pick < 97) begin
            send(OP_REG_WRITE, 4'($urandom_range(0, 15)), 13'($urandom), $urandom);
        end else begin
            send(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 4'($urandom),
                 13'($urandom), $urandom);
        end
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_item();
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_timing(CFG_PROGRAM_TICKS, 16'd3);
        set_timing(CFG_ERASE_TICKS, 16'd5);

        // Directed accesses while locked.
        for (int r = 0; r <= 8; r++) send(OP_REG_READ, 4'(r), '0, '0);
        send(OP_FLASH_READ, '0, '0, '0);
        send(OP_FLASH_READ, '0, 13'h1FFF, '0);
        send(OP_FLASH_PROG, '0, 13'd7, 32'h0000_1234);
        write_reg(REG_CONTROL, 32'h1);
        write_reg(REG_ADDRESS, 32'hFFFF_FFFF);
        send(OP_SPARE_LO, '0, '0, '0);
        send(OP_SPARE_HI, 4'hF, 13'h1FFF, 32'hFFFF_FFFF);
        send(OP_TICK, '0, '0, '0);
        write_reg(REG_KEY, 32'h0);
        write_reg(REG_KEY, KEY_FIRST);
        write_reg(REG_KEY, KEY_FIRST);
        unlock();
        write_reg(REG_KEY, 32'hFFFF_FFFF);
        write_reg(REG_STATUS, 32'hFFFF_FFFF);
        // Program, then hit the busy refusals.
        write_reg(REG_CONTROL, 32'h1);
        send(OP_FLASH_PROG, '0, 13'h1FFF, 32'hABCD_0000);
        send(OP_FLASH_READ, '0, 13'h1FFF, '0);
        write_reg(REG_CONTROL, 32'h80);
        write_reg(REG_ADDRESS, 32'h0800_0400);
        repeat (3) send(OP_TICK, '0, '0, '0);
        send(OP_FLASH_READ, '0, 13'h1FFF, '0);
        write_reg(REG_ADDRESS, 32'h0800_0400);
        write_reg(REG_CONTROL, 32'h42);
        repeat (5) send(OP_TICK, '0, '0, '0);
        write_reg(REG_CONTROL, 32'h46);
        repeat (5) send(OP_TICK, '0, '0, '0);
        write_reg(REG_CONTROL, 32'h41);
        write_reg(REG_CONTROL, 32'hC3);
        send(OP_REG_READ, REG_CONTROL, '0, '0);
        drain();

        // Phase with long output hold: the sender keeps offering items.
        no_idle  = 1'b1;
        hold_req = 1'b1;
        unlock();
        for (int n = 0; n < 40; n++) random_item();
        no_idle = 1'b0;
        random_phase(500);

        set_timing(CFG_PROGRAM_TICKS, 16'd0);
        set_timing(CFG_ERASE_TICKS, 16'd0);
        random_phase(500);

        set_timing(CFG_PROGRAM_TICKS, 16'($urandom_range(1, 8)));
        set_timing(CFG_ERASE_TICKS, 16'($urandom_range(1, 20)));
        random_phase(700);

        // Largest busy counts: one program, then tick it part of the way down.
        set_timing(CFG_PROGRAM_TICKS, 16'hFFFF);
        set_timing(CFG_ERASE_TICKS, 16'hFFFF);
        if (sb.locked) unlock();
        write_reg(REG_CONTROL, 32'h1);
        send(OP_FLASH_PROG, '0, 13'($urandom), $urandom);
        send(OP_REG_READ, REG_STATUS, '0, '0);
        no_idle = 1'b1;
        repeat (20) send(OP_TICK, '0, '0, '0);
        no_idle = 1'b0;
        send(OP_REG_READ, REG_STATUS, '0, '0);
        drain();

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #1s;
        $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
src/fpec_pkg.sv
src/flash_program_erase_controller_unit.sv
sim/tb_top.sv
